@@ src/wtsf_pkg.sv @@
// ----------------------------------------------------------------------------
// wtsf_pkg
// Shared types, constants and helpers of the word tokenizer with stop filter.
// ----------------------------------------------------------------------------
package wtsf_pkg;

  localparam int unsigned MaxWordLen = 32;

  typedef enum logic {
    KIND_TEXT = 1'b0,
    KIND_EOT  = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    STOP_IS,
    STOP_THE,
    STOP_VERY
  } stop_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD
  } state_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] byte_value;
  } in_word_t;

  typedef struct packed {
    logic [7:0] word_char;
    logic       last_of_word;
  } out_word_t;

  function automatic logic is_letter(logic [7:0] b);
    return b inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h80:8'hFF]};
  endfunction

  // character of a stop word at a given position
  function automatic logic [7:0] stop_char(stop_e w, logic [1:0] p);
    logic [7:0] c;
    c = 8'h00;
    case (w)
      STOP_IS: begin
        case (p)
          2'd0:    c = "i";
          2'd1:    c = "s";
          default: c = 8'h00;
        endcase
      end
      STOP_THE: begin
        case (p)
          2'd0:    c = "t";
          2'd1:    c = "h";
          2'd2:    c = "e";
          default: c = 8'h00;
        endcase
      end
      STOP_VERY: begin
        case (p)
          2'd0:    c = "v";
          2'd1:    c = "e";
          2'd2:    c = "r";
          default: c = "y";
        endcase
      end
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

@@ src/wtsf_mem.sv @@
// ----------------------------------------------------------------------------
// wtsf_mem
// Word buffer: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module wtsf_mem #(
  parameter int unsigned Depth = 32,
  parameter int unsigned IdxW  = $clog2(Depth)
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [IdxW-1:0] waddr_i,
  input  logic [7:0]      wdata_i,
  input  logic            re_i,
  input  logic [IdxW-1:0] raddr_i,
  output logic [7:0]      rdata_o
);

  logic [7:0] mem_q [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/word_tokenizer_stop_filter_top.sv @@
// ----------------------------------------------------------------------------
// word_tokenizer_stop_filter_top
// Splits a byte stream into words and drops the stop words is, the and very.
// ----------------------------------------------------------------------------
// Input words are taken while idle; each letter is written to the word
// buffer memory. When a word ends (separator, end of text or a full buffer)
// and it is not a stop word, its characters are read back from the buffer
// memory and sent one per output word, with last_of_word on the final one.
// Each character is read from memory in ST_READ, which waits while the output
// register holds an untaken word, then loaded in ST_LOAD, and new input is
// held off until the final one is loaded; letters and words that give no
// output do not hold it off. Stop words are recognized as the letters arrive.
module word_tokenizer_stop_filter_top #(
  parameter int unsigned MAX_WORD_LEN = wtsf_pkg::MaxWordLen
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  wtsf_pkg::in_word_t   in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output wtsf_pkg::out_word_t  out_word_o
);

  import wtsf_pkg::*;

  localparam int unsigned LenW = $clog2(MAX_WORD_LEN + 1);
  localparam int unsigned IdxW = $clog2(MAX_WORD_LEN);

  state_e          state_q, state_d;
  logic [LenW-1:0] len_q, len_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [2:0]      match_q, match_d;
  logic            out_valid_q, out_valid_d;
  out_word_t       out_q, out_d;

  logic            we, re;
  logic [7:0]      rdata;
  logic            fin;
  logic [LenW-1:0] fin_len, len_inc;
  logic [2:0]      fin_match, match_new;
  logic            stop, last;
  logic [7:0]      b;

  wtsf_mem #(
    .Depth(MAX_WORD_LEN),
    .IdxW (IdxW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(len_q[IdxW-1:0]),
    .wdata_i(in_word_i.byte_value),
    .re_i   (re),
    .raddr_i(idx_q),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= '0;
      idx_q       <= '0;
      match_q     <= '1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      idx_q       <= idx_d;
      match_q     <= match_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_comb begin
    b         = in_word_i.byte_value;
    len_inc   = len_q + LenW'(1);
    match_new[STOP_IS]   = match_q[STOP_IS] && (len_q < LenW'(2)) &&
                           (b == stop_char(STOP_IS, len_q[1:0]));
    match_new[STOP_THE]  = match_q[STOP_THE] && (len_q < LenW'(3)) &&
                           (b == stop_char(STOP_THE, len_q[1:0]));
    match_new[STOP_VERY] = match_q[STOP_VERY] && (len_q < LenW'(4)) &&
                           (b == stop_char(STOP_VERY, len_q[1:0]));

    state_d     = state_q;
    len_d       = len_q;
    idx_d       = idx_q;
    match_d     = match_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    in_ready_o  = 1'b0;
    we          = 1'b0;
    re          = 1'b0;
    fin         = 1'b0;
    fin_len     = len_q;
    fin_match   = match_q;
    last        = (LenW'(idx_q) + LenW'(1)) == len_q;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_word_i.kind == KIND_TEXT && is_letter(b)) begin
            we = 1'b1;
            if (len_inc == LenW'(MAX_WORD_LEN)) begin
              fin       = 1'b1;
              fin_len   = len_inc;
              fin_match = match_new;
            end else begin
              len_d   = len_inc;
              match_d = match_new;
            end
          end else begin
            fin = 1'b1;
          end
        end
      end
      ST_READ: begin
        if (!out_valid_q || out_ready_i) begin
          re      = 1'b1;
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        out_valid_d        = 1'b1;
        out_d.word_char    = rdata;
        out_d.last_of_word = last;
        if (last) begin
          state_d = ST_IDLE;
          len_d   = '0;
          match_d = '1;
        end else begin
          idx_d   = idx_q + IdxW'(1);
          state_d = ST_READ;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    stop = (fin_len == LenW'(2) && fin_match[STOP_IS])  ||
           (fin_len == LenW'(3) && fin_match[STOP_THE]) ||
           (fin_len == LenW'(4) && fin_match[STOP_VERY]);

    if (fin) begin
      if (fin_len != '0 && !stop) begin
        state_d = ST_READ;
        len_d   = fin_len;
        idx_d   = '0;
      end else begin
        len_d   = '0;
        match_d = '1;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

@@ src/wtsf_chk.sv @@
// ----------------------------------------------------------------------------
// wtsf_chk
// Port-level checks of the word tokenizer with stop filter, bound to the top.
// ----------------------------------------------------------------------------
module wtsf_chk (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input wtsf_pkg::in_word_t  in_word_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input wtsf_pkg::out_word_t out_word_o
);

  // stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_word_o))
    else $error("output word changed while stalled");

  // no input taken in the middle of a word
  a_busy_mid_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_word_o.last_of_word |=> !in_ready_o)
    else $error("input accepted during word output");

  a_new_char_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) && !out_word_o.last_of_word |-> !in_ready_o)
    else $error("input ready before word finished");

endmodule

bind word_tokenizer_stop_filter_top wtsf_chk u_wtsf_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .in_word_i  (in_word_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_word_o (out_word_o)
);

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the word tokenizer with stop filter.
// ----------------------------------------------------------------------------
// Byte and end-of-text words are pushed through the valid/ready input, and a
// local tokenizer predicts the characters of every finished non-stop word.
// Output words are compared field by field against that prediction in order.
// Directed tests cover letter range edges, stop words, words cut at the
// maximum length and flushes with nothing pending. Random phases follow,
// mostly short words, stop-word lookalikes and long words, with noise mixed
// in. Sender gaps and receiver stalls vary per phase, and one long receiver
// hold-off backs the block up.
// ----------------------------------------------------------------------------
module tb_top;
  import wtsf_pkg::*;

  localparam int unsigned WordMax    = MaxWordLen;
  localparam int          CycleLimit = 1000000;
  localparam int          TailCycles = 2 * WordMax + 8;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_word_t  in_word_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_word_t out_word_o;

  logic [7:0]  pend_buf [WordMax];
  int unsigned pend_len = 0;
  out_word_t   due_chars [$];
  out_word_t   due_char;
  int          errors = 0;
  int          cycle_count = 0;
  int          words_sent = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          hold_left = 0;

  string lookalikes [10] = '{"is", "the", "very", "Is", "THE", "thee", "ver", "iss", "Very",
                             "th"};

  word_tokenizer_stop_filter_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver side, with a counted hold-off
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic bit is_word_byte(logic [7:0] b);
    return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") || b > 8'h7F;
  endfunction

  function automatic bit pending_is_stop();
    case (pend_len)
      2: return pend_buf[0] == "i" && pend_buf[1] == "s";
      3: return pend_buf[0] == "t" && pend_buf[1] == "h" && pend_buf[2] == "e";
      4: return pend_buf[0] == "v" && pend_buf[1] == "e" && pend_buf[2] == "r" &&
                pend_buf[3] == "y";
      default: return 1'b0;
    endcase
  endfunction

  function automatic void flush_pending();
    if (pend_len > 0 && !pending_is_stop()) begin
      for (int unsigned i = 0; i < pend_len; i++) begin
        due_chars.push_back('{word_char: pend_buf[i], last_of_word: (i + 1 == pend_len)});
      end
    end
    pend_len = 0;
  endfunction

  function automatic void tokenize_word(in_word_t w);
    if (w.kind == KIND_EOT || !is_word_byte(w.byte_value)) begin
      flush_pending();
    end else begin
      if (pend_len >= WordMax) pend_len = 0;
      pend_buf[pend_len] = w.byte_value;
      pend_len++;
      if (pend_len == WordMax) flush_pending();
    end
  endfunction

  // output check first, then prediction of the word taken at this edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (due_chars.size() == 0) begin
          $display("%0t: unexpected word expected none got char %h last %b", $time,
                   out_word_o.word_char, out_word_o.last_of_word);
          errors++;
        end else begin
          due_char = due_chars.pop_front();
          if (out_word_o.word_char !== due_char.word_char) begin
            $display("%0t: word_char expected %h got %h", $time, due_char.word_char,
                     out_word_o.word_char);
            errors++;
          end
          if (out_word_o.last_of_word !== due_char.last_of_word) begin
            $display("%0t: last_of_word expected %b got %b", $time,
                     due_char.last_of_word, out_word_o.last_of_word);
            errors++;
          end
        end
      end
      if (in_valid_i && in_ready_o) tokenize_word(in_word_i);
    end
  end

  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    words_sent++;
  endtask

  task automatic send_text(input logic [7:0] b);
    send_word('{kind: KIND_TEXT, byte_value: b});
  endtask

  task automatic send_eot();
    send_word('{kind: KIND_EOT, byte_value: 8'($urandom_range(255))});
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) send_text(s[i]);
  endtask

  function automatic logic [7:0] random_letter();
    case ($urandom_range(2))
      0:       return 8'($urandom_range(8'h5A, 8'h41));
      1:       return 8'($urandom_range(8'h7A, 8'h61));
      default: return 8'($urandom_range(8'hFF, 8'h80));
    endcase
  endfunction

  function automatic logic [7:0] random_separator();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (is_word_byte(b));
    return b;
  endfunction

  task automatic end_word();
    if ($urandom_range(4) == 0) send_eot();
    else send_text(random_separator());
  endtask

  task automatic wait_for_words();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (due_chars.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
  endtask

  task automatic test_letter_bounds();
    send_text(8'h40);
    send_string("AZ");
    send_text(8'h5B);
    send_string("az");
    send_text(8'h7B);
    send_text(8'h80);
    send_text(8'hFF);
    send_text(8'h7F);
    send_text(8'h60);
    send_text(8'h00);
    send_text("Q");
    send_eot();
    wait_for_words();
  endtask

  task automatic test_stop_words();
    send_string("is the very");
    send_eot();
    send_string("Is thee ver");
    send_eot();
    send_eot();
    send_string("th");
    send_eot();
    wait_for_words();
  endtask

  task automatic test_word_limit();
    repeat (WordMax - 1) send_text(random_letter());
    send_text(" ");
    repeat (WordMax) send_text(random_letter());
    send_string("the");
    send_eot();
    wait_for_words();
  endtask

  task automatic test_backpressure();
    @(negedge clk_i);
    hold_left = 400;
    @(posedge clk_i);
    repeat (12) begin
      repeat ($urandom_range(1, 6)) send_text(random_letter());
      end_word();
    end
    wait_for_words();
  endtask

  task automatic test_random_phase(input int idle, input int stall, input int n_words);
    int    stop_at;
    int    pick;
    string w;
    send_idle_pct = idle;
    stall_pct     = stall;
    stop_at       = words_sent + n_words;
    while (words_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        repeat ($urandom_range(1, 6)) send_text(random_letter());
        end_word();
      end else if (pick < 62) begin
        w = lookalikes[$urandom_range(9)];
        send_string(w);
        end_word();
      end else if (pick < 68) begin
        repeat ($urandom_range(WordMax - 4, WordMax + 8)) send_text(random_letter());
        end_word();
      end else if (pick < 76) begin
        send_eot();
      end else begin
        send_word('{kind: ($urandom_range(9) == 0) ? KIND_EOT : KIND_TEXT,
                    byte_value: 8'($urandom_range(255))});
      end
    end
    wait_for_words();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_letter_bounds();
    test_stop_words();
    test_word_limit();
    test_backpressure();
    test_random_phase(0, 0, 64);
    test_random_phase(88, 0, 64);
    test_random_phase(0, 88, 64);
    test_random_phase(26, 26, 64);
    if (errors == 0 && due_chars.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
